FILE: hw/rtl/dobs_pkg.sv
// ----------------------------------------------------------------------------
// dobs_pkg
// Shared types, constants and helpers of the open-row bank scheduler.
// ----------------------------------------------------------------------------
package dobs_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned IdW      = 16;
  localparam int unsigned LatW     = 10;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned RowW     = 22;
  localparam int unsigned TickW    = 32;
  localparam int unsigned StatCntW = 32;

  localparam int unsigned DefBanks      = 4;
  localparam int unsigned DefBankQDepth = 8;
  localparam int unsigned DefInQDepth   = 4;
  localparam int unsigned DefOutDepth   = 8;

  localparam logic [ShiftW-1:0] PageShiftMin = 5'd10;
  localparam logic [ShiftW-1:0] PageShiftMax = 5'd20;
  localparam logic [ShiftW-1:0] PageShiftRst = 5'd11;
  localparam logic [LatW-1:0]   HitLatRst    = 10'd100;
  localparam logic [LatW-1:0]   MissLatRst   = 10'd200;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowHitLat  = 2'd0,
    CfgRowMissLat = 2'd1,
    CfgPageShift  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic             req_valid;
    logic [AddrW-1:0] req_addr;
    logic [IdW-1:0]   req_id;
  } req_t;

  typedef struct packed {
    logic                done_valid;
    logic [AddrW-1:0]    done_addr;
    logic [IdW-1:0]      done_id;
    logic                done_row_hit;
    logic                accepted;
    logic [StatCntW-1:0] hit_count;
    logic [StatCntW-1:0] miss_count;
  } rsp_t;

  // queued request
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [IdW-1:0]   id;
  } entry_t;

  // finished request
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [IdW-1:0]   id;
    logic             hit;
  } cpl_t;

  // head of a bank queue as seen by the completion FIFO
  typedef struct packed {
    logic done;
    cpl_t cpl;
  } bank_head_t;

  // per-bank status toward the top level
  typedef struct packed {
    logic room;
    logic start_hit;
    logic start_miss;
  } bank_stat_t;

  function automatic logic [ShiftW-1:0] clamp_shift(input logic [ShiftW-1:0] s);
    logic [ShiftW-1:0] r;
    r = s;
    if (s < PageShiftMin) r = PageShiftMin;
    if (s > PageShiftMax) r = PageShiftMax;
    return r;
  endfunction

  // shift is already clamped, so the row always fits RowW bits
  function automatic logic [RowW-1:0] row_of(input logic [AddrW-1:0] addr,
                                             input logic [ShiftW-1:0] shift);
    logic [AddrW-1:0] full;
    full = addr >> shift;
    return full[RowW-1:0];
  endfunction

endpackage

FILE: hw/rtl/dobs_shq.sv
// ----------------------------------------------------------------------------
// dobs_shq
// Shifting queue: head always at entry 0, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module dobs_shq #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 48,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_i,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic [WIDTH-1:0] head_o,
  output logic [WIDTH-1:0] second_o,
  output logic [CntW-1:0]  cnt_o
);

  logic [WIDTH-1:0] q_q [DEPTH];
  logic [WIDTH-1:0] q_d [DEPTH];
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_pop;

  assign cnt_pop = cnt_q - CntW'(pop_i);
  assign cnt_d   = cnt_pop + CntW'(push_i);

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_ent
    logic [WIDTH-1:0] shifted;
    if (gi < DEPTH - 1) begin : g_mid
      assign shifted = q_q[gi+1];
    end else begin : g_last
      assign shifted = q_q[gi];
    end

    always_comb begin
      q_d[gi] = pop_i ? shifted : q_q[gi];
      if (push_i && (cnt_pop == CntW'(gi))) q_d[gi] = push_data_i;
    end
  end

  if (DEPTH > 1) begin : g_second
    assign second_o = q_q[1];
  end else begin : g_no_second
    assign second_o = q_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign head_o = q_q[0];
  assign cnt_o  = cnt_q;

endmodule

FILE: hw/rtl/dobs_bank.sv
// ----------------------------------------------------------------------------
// dobs_bank
// One DRAM bank: request queue, head status, open row and ready timer.
// ----------------------------------------------------------------------------
module dobs_bank
  import dobs_pkg::*;
#(
  parameter int unsigned DEPTH = DefBankQDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              move_i,
  input  logic              push_i,
  input  entry_t            push_data_i,
  input  logic [TickW-1:0]  tick_i,
  input  logic [LatW-1:0]   hit_lat_i,
  input  logic [LatW-1:0]   miss_lat_i,
  input  logic [ShiftW-1:0] shift_i,
  output bank_head_t        head_o,
  output bank_stat_t        stat_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t          head, second, head2;
  logic [CntW-1:0] cnt, cnt2;
  logic            started_q, started_d, done_q, done_d, hit_q, hit_d;
  logic            row_open_q, row_open_d;
  logic [RowW-1:0] open_row_q, open_row_d, row;
  logic [TickW-1:0] ready_q, ready_d, since;
  logic            started2, done2, hit2, hit_now, start;

  dobs_shq #(
    .DEPTH (DEPTH),
    .WIDTH ($bits(entry_t))
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (move_i),
    .push_i      (push_i),
    .push_data_i (push_data_i),
    .head_o      (head),
    .second_o    (second),
    .cnt_o       (cnt)
  );

  // state of the bank once a finished head has left
  assign cnt2     = cnt - CntW'(move_i);
  assign head2    = move_i ? second : head;
  assign started2 = move_i ? 1'b0 : started_q;
  assign done2    = move_i ? 1'b0 : done_q;
  assign hit2     = move_i ? 1'b0 : hit_q;

  assign row     = row_of(head2.addr, shift_i);
  assign hit_now = row_open_q && (open_row_q == row);
  assign since   = tick_i - ready_q;
  assign start   = (cnt2 != '0) && !done2 && !started2;

  always_comb begin
    started_d  = started2;
    done_d     = done2;
    hit_d      = hit2;
    row_open_d = row_open_q;
    open_row_d = open_row_q;
    ready_d    = ready_q;
    if ((cnt2 != '0) && !done2) begin
      if (started2) begin
        // ready time reached, wrap-safe
        if (!since[TickW-1]) done_d = 1'b1;
      end else begin
        started_d  = 1'b1;
        hit_d      = hit_now;
        row_open_d = 1'b1;
        open_row_d = row;
        ready_d    = tick_i + TickW'(hit_now ? hit_lat_i : miss_lat_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      done_q     <= 1'b0;
      hit_q      <= 1'b0;
      row_open_q <= 1'b0;
      ready_q    <= '0;
    end else if (fire_i) begin
      started_q  <= started_d;
      done_q     <= done_d;
      hit_q      <= hit_d;
      row_open_q <= row_open_d;
      ready_q    <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) open_row_q <= open_row_d;
  end

  assign head_o.done     = (cnt != '0) && done_q;
  assign head_o.cpl.addr = head.addr;
  assign head_o.cpl.id   = head.id;
  assign head_o.cpl.hit  = hit_q;

  assign stat_o.room       = cnt2 < CntW'(DEPTH);
  assign stat_o.start_hit  = fire_i && start && hit_now;
  assign stat_o.start_miss = fire_i && start && !hit_now;

endmodule

FILE: hw/rtl/dobs_cpl_fifo.sv
// ----------------------------------------------------------------------------
// dobs_cpl_fifo
// Completion FIFO: one pop and up to one insert per bank each tick,
// banks taken in index order while space lasts.
// ----------------------------------------------------------------------------
module dobs_cpl_fifo
  import dobs_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = DefOutDepth,
  parameter int unsigned BANKS     = DefBanks
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  bank_head_t heads_i [BANKS],
  output logic [BANKS-1:0] move_o,
  output logic       head_valid_o,
  output cpl_t       head_o
);

  localparam int unsigned CntW  = $clog2(OUT_DEPTH + 1);
  localparam int unsigned SlotW = $clog2(OUT_DEPTH + BANKS + 1);

  cpl_t             q_q [OUT_DEPTH];
  cpl_t             q_d [OUT_DEPTH];
  logic [CntW-1:0]  cnt_q, cnt_pop;
  logic [SlotW-1:0] slot [BANKS];
  logic [SlotW-1:0] fill;
  logic [BANKS-1:0] mv;
  logic             pop;

  assign pop     = fire_i && (cnt_q != '0);
  assign cnt_pop = cnt_q - CntW'(pop);

  // running slot per bank; a done head goes in only while there is space
  always_comb begin
    fill = SlotW'(cnt_pop);
    for (int b = 0; b < BANKS; b++) begin
      slot[b] = fill;
      mv[b]   = heads_i[b].done && (fill < SlotW'(OUT_DEPTH));
      fill    = fill + SlotW'(mv[b]);
    end
  end

  for (genvar gi = 0; gi < OUT_DEPTH; gi++) begin : g_ent
    cpl_t shifted;
    if (gi < OUT_DEPTH - 1) begin : g_mid
      assign shifted = q_q[gi+1];
    end else begin : g_last
      assign shifted = q_q[gi];
    end

    always_comb begin
      q_d[gi] = pop ? shifted : q_q[gi];
      for (int b = 0; b < BANKS; b++) begin
        if (fire_i && mv[b] && (slot[b] == SlotW'(gi))) q_d[gi] = heads_i[b].cpl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (fire_i) begin
      cnt_q <= CntW'(fill);
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign move_o       = fire_i ? mv : '0;
  assign head_valid_o = cnt_q != '0;
  assign head_o       = q_q[0];

endmodule

FILE: hw/rtl/dram_open_row_bank_scheduler_unit.sv
// ----------------------------------------------------------------------------
// dram_open_row_bank_scheduler_unit
// Open-row DRAM bank scheduler, one request per memory clock tick.
// ----------------------------------------------------------------------------
// Each request on the in channel is one tick; it may carry a new memory
// request (req_valid). The out channel returns exactly one response per
// tick: the completion that left this tick (done_valid), whether the new
// request entered the input queue (accepted), and the running row hit and
// miss counts.
// A request is held in an input register and processed, once the response
// register is free, by one pass of logic over all bank queues, the
// completion FIFO and the input queue, which loads the response register.
// Throughput is one tick per cycle, set by that single pass, while the
// receiver does not stall.
// The config channel, always ready, writes row hit and miss latency and page
// shift; users must write it only while idle, which the unit does not check.
// Reset empties every queue, closes all rows, clears counters and the tick
// counter, and loads the default configuration. No clearing pass is needed.
// When the receiver stalls, the response is held, one more request waits
// in the input register, and in_ready_o drops.
// ----------------------------------------------------------------------------
module dram_open_row_bank_scheduler_unit
  import dobs_pkg::*;
#(
  parameter int unsigned BANKS             = DefBanks,
  parameter int unsigned BANK_QUEUE_DEPTH  = DefBankQDepth,
  parameter int unsigned INPUT_QUEUE_DEPTH = DefInQDepth,
  parameter int unsigned OUT_DEPTH         = DefOutDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  req_t                in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsp_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned BankW = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int unsigned IqCntW = $clog2(INPUT_QUEUE_DEPTH + 1);
  localparam int unsigned StartW = $clog2(BANKS + 1);

  logic              in_valid_q, out_valid_q, fire;
  req_t              in_q;
  rsp_t              rsp_q;
  logic [LatW-1:0]   hit_lat_q, miss_lat_q;
  logic [ShiftW-1:0] shift_q, shift_c;
  logic [TickW-1:0]  tick_q;
  logic [StatCntW-1:0] hits_q, hits_d, misses_q, misses_d;

  entry_t            iq_head, iq_push_data;
  logic [IqCntW-1:0] iq_cnt, iq_cnt_after;
  logic              iq_move, iq_push, accept;
  logic [RowW-1:0]   iq_row;
  logic [BankW-1:0]  bank_sel;

  bank_head_t        heads [BANKS];
  bank_stat_t        stat  [BANKS];
  logic [BANKS-1:0]  room, bank_move, bank_push;
  logic [StartW-1:0] n_hit, n_miss;

  logic              cpl_valid;
  cpl_t              cpl_head;

  // handshakes
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_lat_q  <= HitLatRst;
      miss_lat_q <= MissLatRst;
      shift_q    <= PageShiftRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRowHitLat:  hit_lat_q  <= cfg_data_i[LatW-1:0];
        CfgRowMissLat: miss_lat_q <= cfg_data_i[LatW-1:0];
        CfgPageShift:  shift_q    <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  assign shift_c = clamp_shift(shift_q);

  // input queue
  assign iq_row   = row_of(iq_head.addr, shift_c);
  assign bank_sel = (BANKS > 1) ? iq_row[BankW-1:0] : '0;
  assign iq_move  = fire && (iq_cnt != '0) && room[bank_sel];
  assign iq_cnt_after = iq_cnt - IqCntW'(iq_move);
  assign accept   = in_q.req_valid && (iq_cnt_after < IqCntW'(INPUT_QUEUE_DEPTH));
  assign iq_push  = fire && accept;
  assign iq_push_data.addr = in_q.req_addr;
  assign iq_push_data.id   = in_q.req_id;

  dobs_shq #(
    .DEPTH (INPUT_QUEUE_DEPTH),
    .WIDTH ($bits(entry_t))
  ) u_in_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (iq_move),
    .push_i      (iq_push),
    .push_data_i (iq_push_data),
    .head_o      (iq_head),
    .second_o    (),
    .cnt_o       (iq_cnt)
  );

  // banks
  for (genvar gb = 0; gb < BANKS; gb++) begin : g_bank
    assign bank_push[gb] = iq_move && (bank_sel == BankW'(gb));
    assign room[gb]      = stat[gb].room;

    dobs_bank #(
      .DEPTH (BANK_QUEUE_DEPTH)
    ) u_bank (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .fire_i      (fire),
      .move_i      (bank_move[gb]),
      .push_i      (bank_push[gb]),
      .push_data_i (iq_head),
      .tick_i      (tick_q),
      .hit_lat_i   (hit_lat_q),
      .miss_lat_i  (miss_lat_q),
      .shift_i     (shift_c),
      .head_o      (heads[gb]),
      .stat_o      (stat[gb])
    );
  end

  dobs_cpl_fifo #(
    .OUT_DEPTH (OUT_DEPTH),
    .BANKS     (BANKS)
  ) u_cpl_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .heads_i      (heads),
    .move_o       (bank_move),
    .head_valid_o (cpl_valid),
    .head_o       (cpl_head)
  );

  // hit and miss counters
  always_comb begin
    n_hit  = '0;
    n_miss = '0;
    for (int b = 0; b < BANKS; b++) begin
      n_hit  = n_hit + StartW'(stat[b].start_hit);
      n_miss = n_miss + StartW'(stat[b].start_miss);
    end
  end

  assign hits_d   = hits_q + StatCntW'(n_hit);
  assign misses_d = misses_q + StatCntW'(n_miss);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      hits_q   <= '0;
      misses_q <= '0;
    end else if (fire) begin
      tick_q   <= tick_q + TickW'(1);
      hits_q   <= hits_d;
      misses_q <= misses_d;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q.done_valid   <= cpl_valid;
      rsp_q.done_addr    <= cpl_valid ? cpl_head.addr : '0;
      rsp_q.done_id      <= cpl_valid ? cpl_head.id : '0;
      rsp_q.done_row_hit <= cpl_valid && cpl_head.hit;
      rsp_q.accepted     <= accept;
      rsp_q.hit_count    <= hits_d;
      rsp_q.miss_count   <= misses_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

endmodule

FILE: tb/sv/dram_open_row_bank_scheduler_unit_tb.sv
// ----------------------------------------------------------------------------
// dram_open_row_bank_scheduler_unit_tb
// Self-checking bench for the open-row DRAM bank scheduler: a clocked driver
// feeds ticks from a pending queue in random bursts, a tick-accurate scheduler
// predictor computes each response, and a monitor compares every response
// field by field while the receiver stalls on its own pattern. The timing
// registers are reprogrammed between phases, extremes and out-of-range
// page shifts included.
// ----------------------------------------------------------------------------
module dram_open_row_bank_scheduler_unit_tb;
  import dobs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBanks     = DefBanks;
  localparam int unsigned BankQDepth = DefBankQDepth;
  localparam int unsigned InQDepth   = DefInQDepth;
  localparam int unsigned OutDepth   = DefOutDepth;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseTicks = 108;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [IdW-1:0]   id;
    logic             started;
    logic             done;
    logic             hit;
  } bank_slot_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  req_t                in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rsp_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_e            cfg_index = CfgRowHitLat;
  logic [CfgDataW-1:0] cfg_data  = '0;

  dram_open_row_bank_scheduler_unit #(
    .BANKS            (NBanks),
    .BANK_QUEUE_DEPTH (BankQDepth),
    .INPUT_QUEUE_DEPTH(InQDepth),
    .OUT_DEPTH        (OutDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Scheduler predictor state
  // --------------------------------------------------------------------------
  logic [LatW-1:0]     lat_hit   = HitLatRst;
  logic [LatW-1:0]     lat_miss  = MissLatRst;
  logic [ShiftW-1:0]   shift_cfg = PageShiftRst;
  logic [TickW-1:0]    tick_now  = '0;
  entry_t              in_fifo[$];
  bank_slot_t          bank_q[NBanks][$];
  cpl_t                done_fifo[$];
  logic                row_live[NBanks];
  logic [RowW-1:0]     row_open[NBanks];
  logic [TickW-1:0]    ready_at[NBanks];
  logic [StatCntW-1:0] hit_tally  = '0;
  logic [StatCntW-1:0] miss_tally = '0;

  initial begin
    for (int b = 0; b < NBanks; b++) begin
      row_live[b] = 1'b0;
      row_open[b] = '0;
      ready_at[b] = '0;
    end
  end

  function automatic logic [RowW-1:0] page_row(input logic [AddrW-1:0] addr);
    logic [ShiftW-1:0] s;
    logic [AddrW-1:0]  shifted;
    s = shift_cfg;
    if (s < PageShiftMin) s = PageShiftMin;
    else if (s > PageShiftMax) s = PageShiftMax;
    shifted = addr >> s;
    return shifted[RowW-1:0];
  endfunction

  // One memory tick: emit, retire, schedule, dispatch, enqueue.
  function automatic rsp_t sched_tick(input req_t req);
    rsp_t             rsp;
    cpl_t             cpl;
    bank_slot_t       head;
    entry_t           ent;
    logic [RowW-1:0]  row;
    logic [TickW-1:0] since;
    int unsigned      bk;
    rsp = '0;
    if (done_fifo.size() != 0) begin
      cpl = done_fifo[0];
      done_fifo.delete(0);
      rsp.done_valid   = 1'b1;
      rsp.done_addr    = cpl.addr;
      rsp.done_id      = cpl.id;
      rsp.done_row_hit = cpl.hit;
    end
    for (int b = 0; b < NBanks; b++) begin
      while (bank_q[b].size() != 0 && bank_q[b][0].done && done_fifo.size() < OutDepth) begin
        head = bank_q[b][0];
        bank_q[b].delete(0);
        cpl.addr = head.addr;
        cpl.id   = head.id;
        cpl.hit  = head.hit;
        done_fifo.insert(done_fifo.size(), cpl);
      end
    end
    for (int b = 0; b < NBanks; b++) begin
      if (bank_q[b].size() != 0 && !bank_q[b][0].done) begin
        head = bank_q[b][0];
        if (head.started) begin
          // wrap-safe: reached once the distance is in the lower half
          since = tick_now - ready_at[b];
          if (!since[TickW-1]) head.done = 1'b1;
        end else begin
          row = page_row(head.addr);
          head.hit = row_live[b] && (row_open[b] == row);
          if (head.hit) begin
            ready_at[b] = tick_now + TickW'(lat_hit);
            hit_tally++;
          end else begin
            ready_at[b] = tick_now + TickW'(lat_miss);
            miss_tally++;
          end
          row_live[b] = 1'b1;
          row_open[b] = row;
          head.started = 1'b1;
        end
        bank_q[b][0] = head;
      end
    end
    if (in_fifo.size() != 0) begin
      bk = page_row(in_fifo[0].addr) % NBanks;
      if (bank_q[bk].size() < BankQDepth) begin
        ent = in_fifo[0];
        in_fifo.delete(0);
        head = '0;
        head.addr = ent.addr;
        head.id   = ent.id;
        bank_q[bk].insert(bank_q[bk].size(), head);
      end
    end
    if (req.req_valid && in_fifo.size() < InQDepth) begin
      ent.addr = req.req_addr;
      ent.id   = req.req_id;
      in_fifo.insert(in_fifo.size(), ent);
      rsp.accepted = 1'b1;
    end
    tick_now++;
    rsp.hit_count  = hit_tally;
    rsp.miss_count = miss_tally;
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pending ticks go out in bursts with random gaps
  // --------------------------------------------------------------------------
  req_t pending[$];
  rsp_t rsp_expected[$];
  int   burst_left = 0;
  int   gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) rsp_expected.insert(rsp_expected.size(), sched_tick(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending[0];
          pending.delete(0);
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: quiet windows alternate with windows of stall runs
  // --------------------------------------------------------------------------
  int unsigned cyc_cnt    = 0;
  int          stall_left = 0;

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (cyc_cnt[8] && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  int unsigned err_cnt = 0;
  int unsigned rsp_cnt = 0;
  rsp_t        exp_rsp;

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("response %0d: %s mismatch, expected %h, got %h", rsp_cnt, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (rsp_expected.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("response %0d arrived with none outstanding", rsp_cnt);
      end else begin
        exp_rsp = rsp_expected[0];
        rsp_expected.delete(0);
        check_field("done_valid", exp_rsp.done_valid, out_data.done_valid);
        check_field("done_addr", exp_rsp.done_addr, out_data.done_addr);
        check_field("done_id", exp_rsp.done_id, out_data.done_id);
        check_field("done_row_hit", exp_rsp.done_row_hit, out_data.done_row_hit);
        check_field("accepted", exp_rsp.accepted, out_data.accepted);
        check_field("hit_count", exp_rsp.hit_count, out_data.hit_count);
        check_field("miss_count", exp_rsp.miss_count, out_data.miss_count);
      end
      rsp_cnt++;
    end
  end

  // Abort when no channel moves for too long.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [AddrW-1:0] row_pool[8];

  function automatic req_t rand_req(input int unsigned valid_pct);
    req_t        req;
    int unsigned kind;
    req.req_valid = ($urandom_range(0, 99) < valid_pct);
    req.req_id    = IdW'($urandom_range(0, 65535));
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // same row as a pool entry for any page shift
      req.req_addr = {row_pool[$urandom_range(0, 7)][AddrW-1:10], 10'($urandom)};
    end else if (kind < 80) begin
      req.req_addr = row_pool[$urandom_range(0, 7)] ^ (AddrW'(1) << $urandom_range(10, 31));
    end else begin
      req.req_addr = $urandom;
    end
    return req;
  endfunction

  function automatic req_t mk_req(input logic vld, input logic [AddrW-1:0] addr,
                                  input logic [IdW-1:0] id);
    req_t req;
    req.req_valid = vld;
    req.req_addr  = addr;
    req.req_id    = id;
    return req;
  endfunction

  // Keep cfg_valid high across back-to-back writes; caller lowers it.
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CfgRowHitLat:  lat_hit = val;
      CfgRowMissLat: lat_miss = val;
      default:       shift_cfg = val[ShiftW-1:0];
    endcase
  endtask

  // Check at the falling edge, where the driver's updates have settled,
  // then resume on a rising edge.
  task automatic drain;
    do @(negedge clk_i);
    while (pending.size() != 0 || in_valid || rsp_expected.size() != 0);
    @(posedge clk_i);
  endtask

  initial begin
    logic [LatW-1:0]   hit_plan[NumPhases];
    logic [LatW-1:0]   miss_plan[NumPhases];
    logic [ShiftW-1:0] shift_plan[NumPhases];
    int unsigned       bank1_rows[13];
    int unsigned       pct;

    hit_plan   = '{10'd1, 10'd0, 10'd50, 10'd1, 10'd0, 10'd3, 10'd0, 10'd1023, 10'd1, 10'd1023};
    miss_plan  = '{10'd1, 10'd0, 10'd60, 10'd0, 10'd0, 10'd9, 10'd0, 10'd1, 10'd1023, 10'd1023};
    shift_plan = '{5'd10, 5'd0, 5'd21, 5'd9, 5'd0, 5'd31, 5'd0, 5'd15, 5'd12, 5'd20};
    // fully random settings in two phases
    hit_plan[4]   = LatW'($urandom);
    miss_plan[4]  = LatW'($urandom);
    shift_plan[4] = ShiftW'($urandom);
    hit_plan[6]   = LatW'($urandom);
    miss_plan[6]  = LatW'($urandom);
    shift_plan[6] = ShiftW'($urandom);
    bank1_rows = '{0, 0, 1, 1, 0, 2, 2, 2, 3, 0, 0, 1, 1};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks under the reset settings (page shift 11, bank = addr[12:11]).
    pending.insert(pending.size(), mk_req(1'b0, 32'hFFFF_FFFF, 16'hFFFF));
    pending.insert(pending.size(), mk_req(1'b1, 32'h0000_0000, 16'h0000));
    pending.insert(pending.size(), mk_req(1'b1, 32'h0000_03FF, 16'h0001));
    pending.insert(pending.size(), mk_req(1'b1, 32'hFFFF_FFFF, 16'hFFFF));
    pending.insert(pending.size(), mk_req(1'b1, 32'h8000_0000, 16'h8000));
    // overfill bank 1 so the input queue backs up and refuses
    for (int k = 0; k < 13; k++)
      pending.insert(pending.size(),
                     mk_req(1'b1, (AddrW'(bank1_rows[k]) << 13) | 32'h0000_0800 |
                            AddrW'(k), IdW'(16'h0100 + k)));
    repeat (3) pending.insert(pending.size(), mk_req(1'b0, 32'h0, 16'h0));
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(CfgRowHitLat, hit_plan[ph]);
      write_reg(CfgRowMissLat, miss_plan[ph]);
      // random upper data bits are ignored for the shift register
      write_reg(CfgPageShift, {5'($urandom), shift_plan[ph]});
      cfg_valid <= 1'b0;
      foreach (row_pool[i]) row_pool[i] = $urandom;
      // heavy traffic fills the bank queues before the fast phase drains them
      if (ph == 2) pct = 95;
      else if (ph == 3) pct = 30;
      else pct = $urandom_range(40, 90);
      for (int k = 0; k < PhaseTicks; k++) pending.insert(pending.size(), rand_req(pct));
      // hold the next write until every response is back
      drain();
    end

    repeat (4) @(posedge clk_i);
    err_cnt += rsp_expected.size();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dobs_pkg.sv
hw/rtl/dobs_shq.sv
hw/rtl/dobs_bank.sv
hw/rtl/dobs_cpl_fifo.sv
hw/rtl/dram_open_row_bank_scheduler_unit.sv
tb/sv/dram_open_row_bank_scheduler_unit_tb.sv
